// ----- rtl/rps_pkg.sv -----
// Shared types, constants and helper functions for the reflow profile sequencer.
// Used by rps_cfg_regs, rps_step and reflow_profile_sequencer.
package rps_pkg;

    localparam int RPS_TEMP_FRAC_BITS = 4;
    localparam int RPS_ELAPSED_WIDTH  = 16;

    localparam int TEMP_W    = 13;
    localparam int RAMP_W    = 8;
    localparam int HOLD_W    = 16;
    localparam int PHASE_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 16;
    localparam int IN_DW     = 16;
    localparam int OUT_DW    = 32;

    localparam logic [TEMP_W-1:0] TEMP_SAT = {TEMP_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOAK_TARGET   = 3'd0,
        REG_SOAK_RAMP     = 3'd1,
        REG_SOAK_HOLD     = 3'd2,
        REG_REFLOW_TARGET = 3'd3,
        REG_REFLOW_RAMP   = 3'd4,
        REG_REFLOW_HOLD   = 3'd5,
        REG_COOL_FLOOR    = 3'd6,
        REG_COOL_RAMP     = 3'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_SOAK   = 4'b0010,
        PH_REFLOW = 4'b0100,
        PH_COOL   = 4'b1000
    } phase_t;

    localparam logic [PHASE_W-1:0] PH_CODE_IDLE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_CODE_SOAK   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_CODE_REFLOW = 2'd2;
    localparam logic [PHASE_W-1:0] PH_CODE_COOL   = 2'd3;

    typedef struct packed {
        logic [TEMP_W-1:0] soak_target;
        logic [RAMP_W-1:0] soak_ramp;
        logic [HOLD_W-1:0] soak_hold;
        logic [TEMP_W-1:0] reflow_target;
        logic [RAMP_W-1:0] reflow_ramp;
        logic [HOLD_W-1:0] reflow_hold;
        logic [TEMP_W-1:0] cool_floor;
        logic [RAMP_W-1:0] cool_ramp;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        soak_target:   13'd2400,
        soak_ramp:     8'd16,
        soak_hold:     16'd90,
        reflow_target: 13'd3680,
        reflow_ramp:   8'd16,
        reflow_hold:   16'd60,
        cool_floor:    13'd800,
        cool_ramp:     8'd32
    };

    function automatic phase_t next_phase(input phase_t p);
        phase_t n;
        case (p)
            PH_IDLE:   n = PH_SOAK;
            PH_SOAK:   n = PH_REFLOW;
            PH_REFLOW: n = PH_COOL;
            PH_COOL:   n = PH_IDLE;
            default:   n = PH_IDLE;
        endcase
        return n;
    endfunction

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t p);
        logic [PHASE_W-1:0] c;
        case (p)
            PH_IDLE:   c = PH_CODE_IDLE;
            PH_SOAK:   c = PH_CODE_SOAK;
            PH_REFLOW: c = PH_CODE_REFLOW;
            PH_COOL:   c = PH_CODE_COOL;
            default:   c = PH_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/rps_cfg_regs.sv -----
// Configuration register bank of the reflow profile sequencer.
// Depends on rps_pkg for the register index codes, cfg_t and reset values.
module rps_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [rps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rps_pkg::CFG_DW-1:0]     cfg_wdata,
    output rps_pkg::cfg_t                  cfg
);
    import rps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_SOAK_TARGET:   cfg_next.soak_target   = cfg_wdata[TEMP_W-1:0];
                REG_SOAK_RAMP:     cfg_next.soak_ramp     = cfg_wdata[RAMP_W-1:0];
                REG_SOAK_HOLD:     cfg_next.soak_hold     = cfg_wdata[HOLD_W-1:0];
                REG_REFLOW_TARGET: cfg_next.reflow_target = cfg_wdata[TEMP_W-1:0];
                REG_REFLOW_RAMP:   cfg_next.reflow_ramp   = cfg_wdata[RAMP_W-1:0];
                REG_REFLOW_HOLD:   cfg_next.reflow_hold   = cfg_wdata[HOLD_W-1:0];
                REG_COOL_FLOOR:    cfg_next.cool_floor    = cfg_wdata[TEMP_W-1:0];
                REG_COOL_RAMP:     cfg_next.cool_ramp     = cfg_wdata[RAMP_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/rps_step.sv -----
// Next-state logic of one control pass: press, phase entry, ramp, hold, cooldown.
// Depends on rps_pkg for phase_t, cfg_t and the phase helper functions.
module rps_step #(
    parameter int TEMP_FRAC_BITS = rps_pkg::RPS_TEMP_FRAC_BITS,
    parameter int ELAPSED_WIDTH  = rps_pkg::RPS_ELAPSED_WIDTH
) (
    input  rps_pkg::cfg_t                 cfg,
    input  logic [rps_pkg::TEMP_W-1:0]    meas,
    input  logic                          press,
    input  logic                          tick,
    input  rps_pkg::phase_t               phase_cur,
    input  rps_pkg::phase_t               entered_cur,
    input  logic [rps_pkg::TEMP_W-1:0]    setpoint_cur,
    input  logic [ELAPSED_WIDTH-1:0]      elapsed_cur,
    output rps_pkg::phase_t               phase_nxt,
    output rps_pkg::phase_t               entered_nxt,
    output logic [rps_pkg::TEMP_W-1:0]    setpoint_nxt,
    output logic [ELAPSED_WIDTH-1:0]      elapsed_nxt
);
    import rps_pkg::*;

    localparam int SW = TEMP_W + 1;
    localparam int CW = (ELAPSED_WIDTH > HOLD_W) ? ELAPSED_WIDTH : HOLD_W;
    localparam logic [SW-1:0] HALF     = SW'((1 << TEMP_FRAC_BITS) >> 1);
    localparam logic [SW-1:0] FRAC_CLR = ~SW'((1 << TEMP_FRAC_BITS) - 1);
    localparam logic [ELAPSED_WIDTH-1:0] EL_ONE = ELAPSED_WIDTH'(1);

    logic [SW-1:0]            rnd_sum;
    logic [SW-1:0]            rnd_trunc;
    logic [TEMP_W-1:0]        rnd;
    phase_t                   ph1;
    phase_t                   ent1;
    logic [TEMP_W-1:0]        sp1;
    logic [ELAPSED_WIDTH-1:0] el1;
    logic [ELAPSED_WIDTH-1:0] el_up;
    logic [SW-1:0]            soak_sum;
    logic [SW-1:0]            reflow_sum;
    logic [TEMP_W-1:0]        cool_gap;

    always_comb begin
        rnd_sum   = {1'b0, meas} + HALF;
        rnd_trunc = rnd_sum & FRAC_CLR;
        rnd       = rnd_trunc[SW-1] ? TEMP_SAT : rnd_trunc[TEMP_W-1:0];

        ph1  = press ? next_phase(phase_cur) : phase_cur;
        ent1 = entered_cur;
        sp1  = setpoint_cur;
        el1  = elapsed_cur;
        if (ph1 != PH_IDLE && ph1 != entered_cur) begin
            case (ph1)
                PH_SOAK:   sp1 = (rnd < cfg.soak_target) ? rnd : cfg.soak_target;
                PH_REFLOW: sp1 = (rnd < cfg.reflow_target) ? rnd : cfg.reflow_target;
                PH_COOL:   sp1 = (rnd > cfg.cool_floor) ? rnd : cfg.cool_floor;
                default:   sp1 = setpoint_cur;
            endcase
            el1  = '0;
            ent1 = ph1;
        end

        el_up      = (&el1) ? el1 : el1 + EL_ONE;
        soak_sum   = {1'b0, sp1} + SW'(cfg.soak_ramp);
        reflow_sum = {1'b0, sp1} + SW'(cfg.reflow_ramp);
        cool_gap   = sp1 - cfg.cool_floor;

        phase_nxt    = ph1;
        setpoint_nxt = sp1;
        elapsed_nxt  = el1;
        if (tick) begin
            case (ph1)
                PH_SOAK: begin
                    if (sp1 < cfg.soak_target) begin
                        setpoint_nxt = soak_sum[SW-1] ? TEMP_SAT : soak_sum[TEMP_W-1:0];
                    end else begin
                        elapsed_nxt = el_up;
                        if (CW'(el_up) >= CW'(cfg.soak_hold)) begin
                            phase_nxt = next_phase(ph1);
                        end
                    end
                end
                PH_REFLOW: begin
                    if (sp1 < cfg.reflow_target) begin
                        setpoint_nxt = (reflow_sum > SW'(cfg.reflow_target)) ?
                                       cfg.reflow_target : reflow_sum[TEMP_W-1:0];
                    end else begin
                        elapsed_nxt = el_up;
                        if (CW'(el_up) >= CW'(cfg.reflow_hold)) begin
                            phase_nxt = next_phase(ph1);
                        end
                    end
                end
                PH_COOL: begin
                    if (sp1 > cfg.cool_floor) begin
                        setpoint_nxt = (cool_gap > TEMP_W'(cfg.cool_ramp)) ?
                                       sp1 - TEMP_W'(cfg.cool_ramp) : cfg.cool_floor;
                    end else if (meas <= cfg.cool_floor) begin
                        phase_nxt = next_phase(ph1);
                    end
                    elapsed_nxt = el_up;
                end
                default: begin
                    phase_nxt = ph1;
                end
            endcase
        end

        entered_nxt = (phase_nxt == PH_IDLE) ? PH_IDLE : ent1;
    end

endmodule

// ----- rtl/reflow_profile_sequencer.sv -----
// Top level of the reflow profile sequencer: stream ports, state and result registers.
// Depends on rps_pkg, rps_cfg_regs and rps_step.
//
// Usage:
//   Each transfer on the s_ channel is one control pass carrying the averaged plate
//   temperature and the button-hold and one-second tick flags. Each pass yields
//   exactly one result transfer on the m_ channel with the phase, setpoint,
//   elapsed seconds and heater enable after that pass, in order.
//   The input register loads at the input transfer edge and the result register
//   loads when the pass advances. Throughput: one pass per cycle while the receiver
//   accepts results; the phase state feeds back through a single register, so
//   passes follow back to back.
//   When the receiver stalls, the result register holds and the input register
//   holds one more pass; s_tready drops only when both are full.
//   Configuration writes on cfg_we/cfg_index/cfg_wdata take effect at the next
//   edge and belong to idle periods with no pass in flight.
//   Reset (aresetn low, synchronous): registers return to defaults, phase idle,
//   setpoint and elapsed count zero, both channels empty.
module reflow_profile_sequencer #(
    parameter int TEMP_FRAC_BITS = rps_pkg::RPS_TEMP_FRAC_BITS,
    parameter int ELAPSED_WIDTH  = rps_pkg::RPS_ELAPSED_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [12:0] measured_temp, [13] press_hold, [14] second_tick, [15] zero
    input  logic [rps_pkg::IN_DW-1:0]      s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] phase, [14:2] setpoint, [30:15] elapsed_seconds, [31] heater_enable
    output logic [rps_pkg::OUT_DW-1:0]     m_tdata,
    input  logic                           cfg_we,
    input  logic [rps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rps_pkg::CFG_DW-1:0]     cfg_wdata
);
    import rps_pkg::*;

    localparam int EXT_W = (ELAPSED_WIDTH > HOLD_W) ? ELAPSED_WIDTH : HOLD_W;

    cfg_t                     cfg;
    logic                     in_valid_reg;
    logic [TEMP_W-1:0]        in_meas_reg;
    logic                     in_press_reg;
    logic                     in_tick_reg;
    logic                     out_valid_reg;
    logic [OUT_DW-1:0]        out_data_reg;
    phase_t                   phase_reg;
    phase_t                   entered_reg;
    logic [TEMP_W-1:0]        setpoint_reg;
    logic [ELAPSED_WIDTH-1:0] elapsed_reg;
    phase_t                   phase_next;
    phase_t                   entered_next;
    logic [TEMP_W-1:0]        setpoint_next;
    logic [ELAPSED_WIDTH-1:0] elapsed_next;
    logic [EXT_W-1:0]         elapsed_ext;
    logic                     adv;
    logic                     s_xfer;

    rps_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rps_step #(
        .TEMP_FRAC_BITS (TEMP_FRAC_BITS),
        .ELAPSED_WIDTH  (ELAPSED_WIDTH)
    ) u_step (
        .cfg          (cfg),
        .meas         (in_meas_reg),
        .press        (in_press_reg),
        .tick         (in_tick_reg),
        .phase_cur    (phase_reg),
        .entered_cur  (entered_reg),
        .setpoint_cur (setpoint_reg),
        .elapsed_cur  (elapsed_reg),
        .phase_nxt    (phase_next),
        .entered_nxt  (entered_next),
        .setpoint_nxt (setpoint_next),
        .elapsed_nxt  (elapsed_next)
    );

    assign adv         = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready    = !in_valid_reg || adv;
    assign s_xfer      = s_tvalid && s_tready;
    assign elapsed_ext = EXT_W'(elapsed_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            entered_reg   <= PH_IDLE;
            setpoint_reg  <= '0;
            elapsed_reg   <= '0;
        end else begin
            if (s_xfer) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                entered_reg   <= entered_next;
                setpoint_reg  <= setpoint_next;
                elapsed_reg   <= elapsed_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_meas_reg  <= s_tdata[TEMP_W-1:0];
            in_press_reg <= s_tdata[TEMP_W];
            in_tick_reg  <= s_tdata[TEMP_W+1];
        end
        if (adv) begin
            out_data_reg <= {phase_next != PH_IDLE, elapsed_ext[HOLD_W-1:0],
                             setpoint_next, phase_code(phase_next)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_heater_matches_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_DW-1] == (m_tdata[PHASE_W-1:0] != PH_CODE_IDLE)))
        else $error("heater_enable disagrees with phase");

    a_idle_entered: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (entered_reg == PH_IDLE))
        else $error("entered phase not cleared in idle");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(phase_reg) && $stable(setpoint_reg) && $stable(elapsed_reg)))
        else $error("state changed without a pass");

    a_pass_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> out_valid_reg)
        else $error("pass did not produce a result");
`endif

endmodule
